// ----- rtl/dpb_pkg.sv -----
package dpb_pkg;

    localparam int MAX_DIM    = 4096;
    localparam int CNT_W      = $clog2(MAX_DIM);
    localparam int DIM_W      = 13;
    localparam int DEPTH_W    = 16;
    localparam int COLOR_W    = 8;
    localparam int COORD_W    = 24;
    localparam int CENTER_W   = 16;
    localparam int INVF_W     = 24;
    localparam int FMT_W      = 2;
    localparam int MAG_W      = CENTER_W;
    localparam int PROD_W     = MAG_W + DEPTH_W;
    localparam int FULL_W     = PROD_W + INVF_W;
    localparam int FRAC_SHIFT = 28;
    localparam int QUOT_W     = FULL_W - FRAC_SHIFT + 1;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CENTER_X     = 3'd0,
        REG_CENTER_Y     = 3'd1,
        REG_INV_FOCAL_X  = 3'd2,
        REG_INV_FOCAL_Y  = 3'd3,
        REG_FRAME_WIDTH  = 3'd4,
        REG_FRAME_HEIGHT = 3'd5,
        REG_PIXEL_FORMAT = 3'd6
    } cfg_reg_t;

    localparam logic [FMT_W-1:0] FMT_RGB8  = 2'd0;
    localparam logic [FMT_W-1:0] FMT_BGR8  = 2'd1;
    localparam logic [FMT_W-1:0] FMT_MONO8 = 2'd2;

    localparam logic [CENTER_W-1:0] RST_CENTER_X = 16'd5112;
    localparam logic [CENTER_W-1:0] RST_CENTER_Y = 16'd3832;
    localparam logic [INVF_W-1:0]   RST_INV_FOCAL = 24'd31957;
    localparam logic [DIM_W-1:0]    RST_WIDTH    = 13'd640;
    localparam logic [DIM_W-1:0]    RST_HEIGHT   = 13'd480;

    localparam logic [COORD_W-1:0] SAT_POS = 24'h7FFFFF;
    localparam logic [COORD_W-1:0] SAT_NEG = 24'h800000;

    typedef struct packed {
        logic load;
        logic mul_a;
        logic mul_b;
        logic emit;
    } dpb_cmd_t;

    typedef struct packed {
        logic out_full;
    } dpb_stat_t;

endpackage

// ----- rtl/dpb_pixel_if.sv -----
interface dpb_pixel_if;
    import dpb_pkg::*;

    logic               valid;
    logic               ready;
    logic [DEPTH_W-1:0] depth_mm;
    logic [COLOR_W-1:0] chan0;
    logic [COLOR_W-1:0] chan1;
    logic [COLOR_W-1:0] chan2;

    modport source (output valid, output depth_mm, output chan0, output chan1,
                    output chan2, input ready);
    modport sink   (input valid, input depth_mm, input chan0, input chan1,
                    input chan2, output ready);
endinterface

// ----- rtl/dpb_point_if.sv -----
interface dpb_point_if;
    import dpb_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [DEPTH_W-1:0]        point_z;
    logic                      point_valid;
    logic [COLOR_W-1:0]        red;
    logic [COLOR_W-1:0]        green;
    logic [COLOR_W-1:0]        blue;
    logic                      frame_end;

    modport source (output valid, output point_x, output point_y, output point_z,
                    output point_valid, output red, output green, output blue,
                    output frame_end, input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    input point_valid, input red, input green, input blue,
                    input frame_end, output ready);
endinterface

// ----- rtl/depth_pixel_backprojection_core.sv -----
// Channel   Role    Payload
// pixel     sink    depth_mm, chan0, chan1, chan2
// point     source  point_x, point_y, point_z, point_valid, red, green, blue, frame_end
// cfg_*     write   cfg_index selects the register, cfg_data carries the value
//
// Each pixel goes through four steps: accept, depth multiply, focal multiply, round and
// saturate into the output register; the middle two are the multiplier stages.
// A new pixel is taken while the previous point still waits in the output register.
// A stalled point sink holds the final step until the output register is free.
// Reset restores the default calibration and clears the raster counters.
module depth_pixel_backprojection_core (
    input  logic                           clk,
    input  logic                           rst_n,
    dpb_pixel_if.sink                      pixel,
    dpb_point_if.source                    point,
    input  logic                           cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dpb_pkg::*;

    dpb_cmd_t  cmd;
    dpb_stat_t stat;

    dpb_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (pixel.valid),
        .in_ready (pixel.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    dpb_datapath u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .stat        (stat),
        .depth_mm    (pixel.depth_mm),
        .chan0       (pixel.chan0),
        .chan1       (pixel.chan1),
        .chan2       (pixel.chan2),
        .out_valid   (point.valid),
        .out_ready   (point.ready),
        .point_x     (point.point_x),
        .point_y     (point.point_y),
        .point_z     (point.point_z),
        .point_valid (point.point_valid),
        .red         (point.red),
        .green       (point.green),
        .blue        (point.blue),
        .frame_end   (point.frame_end)
    );
endmodule

// ----- rtl/dpb_ctrl.sv -----
module dpb_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  dpb_pkg::dpb_stat_t stat,
    output dpb_pkg::dpb_cmd_t  cmd
);
    import dpb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_MUL_A;
                end
            end
            S_MUL_A: state_next = S_MUL_B;
            S_MUL_B: state_next = S_EMIT;
            S_EMIT:
            begin
                // hold until the output register is free
                if (!stat.out_full)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign cmd.load  = (state_reg == S_IDLE) && in_valid;
    assign cmd.mul_a = (state_reg == S_MUL_A);
    assign cmd.mul_b = (state_reg == S_MUL_B);
    assign cmd.emit  = (state_reg == S_EMIT) && !stat.out_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

// ----- rtl/dpb_datapath.sv -----
module dpb_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [dpb_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [dpb_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  dpb_pkg::dpb_cmd_t                  cmd,
    output dpb_pkg::dpb_stat_t                 stat,
    input  logic [dpb_pkg::DEPTH_W-1:0]        depth_mm,
    input  logic [dpb_pkg::COLOR_W-1:0]        chan0,
    input  logic [dpb_pkg::COLOR_W-1:0]        chan1,
    input  logic [dpb_pkg::COLOR_W-1:0]        chan2,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [dpb_pkg::COORD_W-1:0] point_x,
    output logic signed [dpb_pkg::COORD_W-1:0] point_y,
    output logic [dpb_pkg::DEPTH_W-1:0]        point_z,
    output logic                               point_valid,
    output logic [dpb_pkg::COLOR_W-1:0]        red,
    output logic [dpb_pkg::COLOR_W-1:0]        green,
    output logic [dpb_pkg::COLOR_W-1:0]        blue,
    output logic                               frame_end
);
    import dpb_pkg::*;

    // configuration
    logic [CENTER_W-1:0] center_x_reg;
    logic [CENTER_W-1:0] center_y_reg;
    logic [INVF_W-1:0]   inv_x_reg;
    logic [INVF_W-1:0]   inv_y_reg;
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [FMT_W-1:0]    format_reg;

    // raster position
    logic [CNT_W-1:0] col_reg;
    logic [CNT_W-1:0] row_reg;
    logic [CNT_W-1:0] col_next;
    logic [CNT_W-1:0] row_next;

    logic [DIM_W-1:0] width_eff;
    logic [DIM_W-1:0] height_eff;
    logic             row_last;
    logic             frame_last;

    logic [CENTER_W-1:0] pos_x;
    logic [CENTER_W-1:0] pos_y;
    logic                neg_x;
    logic                neg_y;
    logic [MAG_W-1:0]    mag_x;
    logic [MAG_W-1:0]    mag_y;

    // stage registers
    logic [MAG_W-1:0]   mag_x_reg;
    logic [MAG_W-1:0]   mag_y_reg;
    logic               neg_x_reg;
    logic               neg_y_reg;
    logic [DEPTH_W-1:0] z_reg;
    logic [COLOR_W-1:0] r_reg;
    logic [COLOR_W-1:0] g_reg;
    logic [COLOR_W-1:0] b_reg;
    logic               last_reg;
    logic [PROD_W-1:0]  prod_x_reg;
    logic [PROD_W-1:0]  prod_y_reg;
    logic [FULL_W-1:0]  full_x_reg;
    logic [FULL_W-1:0]  full_y_reg;

    // output register
    logic                      out_valid_reg;
    logic                      out_valid_next;
    logic signed [COORD_W-1:0] out_x_reg;
    logic signed [COORD_W-1:0] out_y_reg;
    logic [DEPTH_W-1:0]        out_z_reg;
    logic                      out_pv_reg;
    logic [COLOR_W-1:0]        out_r_reg;
    logic [COLOR_W-1:0]        out_g_reg;
    logic [COLOR_W-1:0]        out_b_reg;
    logic                      out_last_reg;

    function automatic logic [COORD_W-1:0] round_sat(input logic [FULL_W-1:0] f,
                                                     input logic neg);
        logic [QUOT_W-1:0]  q;
        logic [COORD_W-1:0] res;
        q = {1'b0, f[FULL_W-1:FRAC_SHIFT]};
        if (neg)
        begin
            // floor of a negative value: round the magnitude up
            if (f[FRAC_SHIFT-1:0] != '0)
            begin
                q = q + QUOT_W'(1);
            end
            if (q >= QUOT_W'(SAT_NEG))
            begin
                res = SAT_NEG;
            end
            else
            begin
                res = COORD_W'(QUOT_W'(0) - q);
            end
        end
        else
        begin
            if (q > QUOT_W'(SAT_POS))
            begin
                res = SAT_POS;
            end
            else
            begin
                res = q[COORD_W-1:0];
            end
        end
        return res;
    endfunction

    always_comb
    begin
        width_eff  = width_reg;
        height_eff = height_reg;
        if (width_reg == '0)
        begin
            width_eff = DIM_W'(1);
        end
        else if (width_reg > DIM_W'(MAX_DIM))
        begin
            width_eff = DIM_W'(MAX_DIM);
        end
        if (height_reg == '0)
        begin
            height_eff = DIM_W'(1);
        end
        else if (height_reg > DIM_W'(MAX_DIM))
        begin
            height_eff = DIM_W'(MAX_DIM);
        end
    end

    assign row_last   = (DIM_W'(col_reg) + DIM_W'(1)) >= width_eff;
    assign frame_last = row_last && ((DIM_W'(row_reg) + DIM_W'(1)) >= height_eff);

    always_comb
    begin
        col_next = col_reg + CNT_W'(1);
        row_next = row_reg;
        if (row_last)
        begin
            col_next = '0;
            row_next = frame_last ? '0 : row_reg + CNT_W'(1);
        end
    end

    assign pos_x = {col_reg, 4'b0000};
    assign pos_y = {row_reg, 4'b0000};
    assign neg_x = pos_x < center_x_reg;
    assign neg_y = pos_y < center_y_reg;
    assign mag_x = neg_x ? center_x_reg - pos_x : pos_x - center_x_reg;
    assign mag_y = neg_y ? center_y_reg - pos_y : pos_y - center_y_reg;

    assign out_valid_next = cmd.emit ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg  <= RST_CENTER_X;
            center_y_reg  <= RST_CENTER_Y;
            inv_x_reg     <= RST_INV_FOCAL;
            inv_y_reg     <= RST_INV_FOCAL;
            width_reg     <= RST_WIDTH;
            height_reg    <= RST_HEIGHT;
            format_reg    <= FMT_RGB8;
            col_reg       <= '0;
            row_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CENTER_X:     center_x_reg <= cfg_data[CENTER_W-1:0];
                    REG_CENTER_Y:     center_y_reg <= cfg_data[CENTER_W-1:0];
                    REG_INV_FOCAL_X:  inv_x_reg    <= cfg_data[INVF_W-1:0];
                    REG_INV_FOCAL_Y:  inv_y_reg    <= cfg_data[INVF_W-1:0];
                    REG_FRAME_WIDTH:  width_reg    <= cfg_data[DIM_W-1:0];
                    REG_FRAME_HEIGHT: height_reg   <= cfg_data[DIM_W-1:0];
                    REG_PIXEL_FORMAT: format_reg   <= cfg_data[FMT_W-1:0];
                    default:          ;
                endcase
            end
            if (cmd.load)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mag_x_reg <= mag_x;
            mag_y_reg <= mag_y;
            neg_x_reg <= neg_x;
            neg_y_reg <= neg_y;
            z_reg     <= depth_mm;
            last_reg  <= frame_last;
            case (format_reg)
                FMT_MONO8:
                begin
                    r_reg <= chan0;
                    g_reg <= chan0;
                    b_reg <= chan0;
                end
                FMT_BGR8:
                begin
                    r_reg <= chan2;
                    g_reg <= chan1;
                    b_reg <= chan0;
                end
                default:
                begin
                    r_reg <= chan0;
                    g_reg <= chan1;
                    b_reg <= chan2;
                end
            endcase
        end
        if (cmd.mul_a)
        begin
            prod_x_reg <= PROD_W'(mag_x_reg) * PROD_W'(z_reg);
            prod_y_reg <= PROD_W'(mag_y_reg) * PROD_W'(z_reg);
        end
        if (cmd.mul_b)
        begin
            full_x_reg <= FULL_W'(prod_x_reg) * FULL_W'(inv_x_reg);
            full_y_reg <= FULL_W'(prod_y_reg) * FULL_W'(inv_y_reg);
        end
        if (cmd.emit)
        begin
            // zero depth gives zero products, so coordinates come out zero
            out_x_reg    <= round_sat(full_x_reg, neg_x_reg);
            out_y_reg    <= round_sat(full_y_reg, neg_y_reg);
            out_z_reg    <= z_reg;
            out_pv_reg   <= (z_reg != '0);
            out_r_reg    <= r_reg;
            out_g_reg    <= g_reg;
            out_b_reg    <= b_reg;
            out_last_reg <= last_reg;
        end
    end

    assign stat.out_full = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign point_x       = out_x_reg;
    assign point_y       = out_y_reg;
    assign point_z       = out_z_reg;
    assign point_valid   = out_pv_reg;
    assign red           = out_r_reg;
    assign green         = out_g_reg;
    assign blue          = out_b_reg;
    assign frame_end     = out_last_reg;
endmodule

// ----- test/dpb_point_checker.sv -----
module dpb_point_checker
    import dpb_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    dpb_pixel_if                  pixel,
    dpb_point_if                  point,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    errors,
    output int                    pending
);

    localparam int    REPORT_LIMIT = 10;
    localparam longint COORD_MAX   = (longint'(1) <<< (COORD_W - 1)) - 1;
    localparam longint COORD_MIN   = -(longint'(1) <<< (COORD_W - 1));

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DEPTH_W-1:0]        z;
        logic                      valid;
        logic [COLOR_W-1:0]        red;
        logic [COLOR_W-1:0]        green;
        logic [COLOR_W-1:0]        blue;
        logic                      frame_end;
    } point_t;

    logic [CENTER_W-1:0] center_x;
    logic [CENTER_W-1:0] center_y;
    logic [INVF_W-1:0]   inv_fx;
    logic [INVF_W-1:0]   inv_fy;
    logic [DIM_W-1:0]    width;
    logic [DIM_W-1:0]    height;
    logic [FMT_W-1:0]    format;
    int unsigned         column;
    int unsigned         row;
    point_t              expected_points[$];

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] d);
        if (d == 0)
            return 1;
        if (d > MAX_DIM)
            return MAX_DIM;
        return d;
    endfunction

    // floor((16*pos - centre) * z * inv / 2^28), clamped to the coordinate range
    function automatic logic [COORD_W-1:0] project_axis(int unsigned pos,
                                                        logic [CENTER_W-1:0] centre,
                                                        logic [DEPTH_W-1:0] z,
                                                        logic [INVF_W-1:0] inv);
        longint offset;
        longint product;
        longint quotient;
        offset   = longint'(pos) * 16 - longint'(centre);
        product  = offset * longint'(z) * longint'(inv);
        quotient = product >>> FRAC_SHIFT;
        if (quotient > COORD_MAX)
            return SAT_POS;
        if (quotient < COORD_MIN)
            return SAT_NEG;
        return quotient[COORD_W-1:0];
    endfunction

    function automatic point_t project_pixel(logic [DEPTH_W-1:0] z, logic [COLOR_W-1:0] c0,
                                             logic [COLOR_W-1:0] c1, logic [COLOR_W-1:0] c2);
        point_t      p;
        int unsigned w;
        int unsigned h;
        bit          row_last;
        w           = clamp_dim(width);
        h           = clamp_dim(height);
        // counters at or past the size close the row (and frame) here
        row_last    = (column + 1) >= w;
        p.frame_end = row_last && ((row + 1) >= h);
        p.valid     = (z != 0);
        p.z         = z;
        p.x         = p.valid ? project_axis(column, center_x, z, inv_fx) : '0;
        p.y         = p.valid ? project_axis(row, center_y, z, inv_fy) : '0;
        case (format)
            FMT_MONO8: {p.red, p.green, p.blue} = {c0, c0, c0};
            FMT_BGR8:  {p.red, p.green, p.blue} = {c2, c1, c0};
            default:   {p.red, p.green, p.blue} = {c0, c1, c2};
        endcase
        if (row_last)
        begin
            column = 0;
            row    = p.frame_end ? 0 : row + 1;
        end
        else
        begin
            column = column + 1;
        end
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        point_t got;
        point_t want;
        if (!rst_n)
        begin
            center_x = RST_CENTER_X;
            center_y = RST_CENTER_Y;
            inv_fx   = RST_INV_FOCAL;
            inv_fy   = RST_INV_FOCAL;
            width    = RST_WIDTH;
            height   = RST_HEIGHT;
            format   = FMT_RGB8;
            column   = 0;
            row      = 0;
            errors   = 0;
            expected_points.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_CENTER_X:     center_x = cfg_data[CENTER_W-1:0];
                    REG_CENTER_Y:     center_y = cfg_data[CENTER_W-1:0];
                    REG_INV_FOCAL_X:  inv_fx   = cfg_data[INVF_W-1:0];
                    REG_INV_FOCAL_Y:  inv_fy   = cfg_data[INVF_W-1:0];
                    REG_FRAME_WIDTH:  width    = cfg_data[DIM_W-1:0];
                    REG_FRAME_HEIGHT: height   = cfg_data[DIM_W-1:0];
                    REG_PIXEL_FORMAT: format   = cfg_data[FMT_W-1:0];
                    default: ;
                endcase
            end

            if (pixel.valid && pixel.ready)
                expected_points.insert(expected_points.size(),
                                       project_pixel(pixel.depth_mm, pixel.chan0,
                                                     pixel.chan1, pixel.chan2));

            if (point.valid && point.ready)
            begin
                got = '{point.point_x, point.point_y, point.point_z, point.point_valid,
                        point.red, point.green, point.blue, point.frame_end};
                if (expected_points.size() == 0)
                begin
                    if (errors < REPORT_LIMIT)
                        $display("%0t: point with no request pending: x=%0d y=%0d z=%0d",
                                 $time, $signed(got.x), $signed(got.y), got.z);
                    errors++;
                end
                else
                begin
                    want = expected_points.pop_front();
                    if (got !== want)
                    begin
                        if (errors < REPORT_LIMIT)
                        begin
                            $display("%0t: point mismatch", $time);
                            $display("  expected x=%0d y=%0d z=%0d valid=%0b rgb=%h/%h/%h end=%0b",
                                     $signed(want.x), $signed(want.y), want.z, want.valid,
                                     want.red, want.green, want.blue, want.frame_end);
                            $display("  actual   x=%0d y=%0d z=%0d valid=%0b rgb=%h/%h/%h end=%0b",
                                     $signed(got.x), $signed(got.y), got.z, got.valid,
                                     got.red, got.green, got.blue, got.frame_end);
                        end
                        errors++;
                    end
                end
            end
            pending <= expected_points.size();
        end
    end

endmodule

// ----- test/tb.sv -----
module tb;
    import dpb_pkg::*;

    localparam int CLK_PERIOD    = 8;
    localparam int RESET_CYCLES  = 12;
    localparam int PHASE_ITEMS   = 250;
    localparam int RANDOM_PHASES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 8;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 3'd7;
    localparam logic [FMT_W-1:0]     FMT_UNKNOWN = 2'd3;

    typedef struct {
        logic [CENTER_W-1:0] center_x;
        logic [CENTER_W-1:0] center_y;
        logic [INVF_W-1:0]   inv_fx;
        logic [INVF_W-1:0]   inv_fy;
        logic [DIM_W-1:0]    width;
        logic [DIM_W-1:0]    height;
        logic [FMT_W-1:0]    format;
    } calib_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors;
    int                    pending;
    int                    cycle_count = 0;
    int                    sender_idle_pct;
    int                    stall_pct;
    bit                    hold_req;

    dpb_pixel_if pixel_ch();
    dpb_point_if point_ch();

    depth_pixel_backprojection_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .point     (point_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dpb_point_checker point_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pixel_ch),
        .point     (point_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // point sink: random stalls, or a long hold-off when requested
    initial
    begin
        int hold_left;
        hold_left = 0;
        point_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && hold_left == 0)
            begin
                hold_left = HOLD_CYCLES;
                hold_req  = 1'b0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                point_ch.ready <= 1'b0;
            end
            else
            begin
                point_ch.ready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    // upper data bits beyond each register are random and must be dropped
    task automatic load_calib(input calib_t c);
        write_reg(REG_CENTER_X, {8'($urandom), c.center_x});
        write_reg(REG_CENTER_Y, {8'($urandom), c.center_y});
        write_reg(REG_INV_FOCAL_X, c.inv_fx);
        write_reg(REG_INV_FOCAL_Y, c.inv_fy);
        write_reg(REG_FRAME_WIDTH, {11'($urandom), c.width});
        write_reg(REG_FRAME_HEIGHT, {11'($urandom), c.height});
        write_reg(REG_PIXEL_FORMAT, {22'($urandom), c.format});
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_pixel(input logic [DEPTH_W-1:0] depth, input logic [COLOR_W-1:0] c0,
                              input logic [COLOR_W-1:0] c1, input logic [COLOR_W-1:0] c2);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            pixel_ch.valid <= 1'b0;
            @(posedge clk);
        end
        pixel_ch.valid    <= 1'b1;
        pixel_ch.depth_mm <= depth;
        pixel_ch.chan0    <= c0;
        pixel_ch.chan1    <= c1;
        pixel_ch.chan2    <= c2;
        @(posedge clk);
        while (!pixel_ch.ready)
            @(posedge clk);
    endtask

    function automatic logic [DEPTH_W-1:0] random_depth();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            2:       return DEPTH_W'($urandom_range(1, 255));
            default: return DEPTH_W'($urandom);
        endcase
    endfunction

    task automatic send_random_pixel();
        send_pixel(random_depth(), COLOR_W'($urandom), COLOR_W'($urandom), COLOR_W'($urandom));
    endtask

    // drop valid, then hold the sender until every point is out
    task automatic finish_burst();
        pixel_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CENTER_W-1:0] random_center();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return CENTER_W'($urandom);
        endcase
    endfunction

    function automatic logic [INVF_W-1:0] random_inv_focal();
        case ($urandom_range(3))
            0:       return '1;
            1:       return INVF_W'($urandom_range(1, 255));
            2:       return INVF_W'($urandom_range(20000, 60000));
            default: return INVF_W'($urandom);
        endcase
    endfunction

    // mostly small frames so that frame ends come often
    function automatic calib_t random_calib();
        calib_t c;
        c.center_x = random_center();
        c.center_y = random_center();
        c.inv_fx   = random_inv_focal();
        c.inv_fy   = random_inv_focal();
        case ($urandom_range(7))
            0:       c.width = '0;
            1:       c.width = DIM_W'(MAX_DIM);
            2:       c.width = '1;
            3:       c.width = RST_WIDTH;
            default: c.width = DIM_W'($urandom_range(1, 12));
        endcase
        case ($urandom_range(7))
            0:       c.height = '0;
            1:       c.height = DIM_W'(MAX_DIM);
            2:       c.height = '1;
            default: c.height = DIM_W'($urandom_range(1, 6));
        endcase
        c.format = FMT_W'($urandom_range(3));
        return c;
    endfunction

    initial
    begin
        calib_t calib;
        int     phase;
        int     n;

        rst_n             <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_index         <= '0;
        cfg_data          <= '0;
        pixel_ch.valid    <= 1'b0;
        pixel_ch.depth_mm <= '0;
        pixel_ch.chan0    <= '0;
        pixel_ch.chan1    <= '0;
        pixel_ch.chan2    <= '0;
        sender_idle_pct = 0;
        stall_pct       = 0;
        hold_req        = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default calibration: missing depth, depth extremes, colour extremes
        send_pixel('0, 8'hFF, 8'h00, 8'hFF);
        send_pixel('1, 8'h00, 8'hFF, 8'h00);
        send_pixel(16'd1, 8'h55, 8'hAA, 8'h0F);
        send_pixel(16'hAAAA, 8'hF0, 8'h5A, 8'hA5);
        finish_burst();

        // far centre with maximum focal inverse: negative saturation, bgr order
        calib = '{'1, '1, '1, '1, 13'd2, 13'd2, FMT_BGR8};
        load_calib(calib);
        send_pixel('1, 8'h12, 8'h34, 8'h56);
        send_pixel('0, 8'hFF, 8'h00, 8'h81);
        send_pixel(16'd1, 8'h7E, 8'h81, 8'hFF);
        send_pixel('1, 8'h00, 8'hFF, 8'h00);
        finish_burst();

        // zero focal inverse, mono, frame sizes out of range
        calib = '{RST_CENTER_X, RST_CENTER_Y, '0, '0, '0, '1, FMT_MONO8};
        load_calib(calib);
        repeat (3) send_random_pixel();
        finish_burst();

        // unknown format, then shrink the row under the running counter
        calib = '{RST_CENTER_X, RST_CENTER_Y, RST_INV_FOCAL, 24'd1, 13'd5, 13'd1, FMT_UNKNOWN};
        load_calib(calib);
        repeat (3) send_random_pixel();
        finish_burst();
        calib.width = 13'd2;
        load_calib(calib);
        repeat (3) send_random_pixel();
        finish_burst();

        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            calib = random_calib();
            if (phase == 0)
            begin
                // long rows reach columns where the positive side saturates
                calib.center_x = '0;
                calib.center_y = '0;
                calib.inv_fx   = '1;
                calib.inv_fy   = '1;
                calib.width    = DIM_W'(MAX_DIM);
                calib.height   = DIM_W'(MAX_DIM);
            end
            load_calib(calib);
            case (phase % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 0;
                    hold_req        = 1'b1;
                end
                1:
                begin
                    sender_idle_pct = 64;
                    stall_pct       = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    stall_pct       = 64;
                end
                default:
                begin
                    sender_idle_pct = 8;
                    stall_pct       = 8;
                end
            endcase
            for (n = 0; n < PHASE_ITEMS; n++)
                send_random_pixel();
            finish_burst();
        end

        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
